FILE: sv/pts_pkg.sv
package pts_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF    = 64;
  localparam int PID_BITS_DEF = 16;

  // Input word layout
  localparam int IN_DW   = 32;
  localparam int IN_UW   = 8;
  localparam int OUT_UW  = 8;
  localparam int WPID_W  = 17;
  localparam int CODE_W  = 8;

  // Operation codes carried in in_tuser
  typedef enum logic [2:0] {
    K_CREATE   = 3'd0,
    K_FORK     = 3'd1,
    K_DISPATCH = 3'd2,
    K_YIELD    = 3'd3,
    K_EXIT     = 3'd4,
    K_WAIT     = 3'd5
  } kind_t;

  // Result codes carried in out_tuser
  typedef enum logic [2:0] {
    OC_OK         = 3'd0,
    OC_FULL       = 3'd1,
    OC_NONE_RUN   = 3'd2,
    OC_NO_CHILD   = 3'd3,
    OC_NONE_READY = 3'd4,
    OC_SLEPT      = 3'd5,
    OC_NO_CUR     = 3'd6
  } outcome_t;

  // Life state of a table entry
  typedef enum logic [2:0] {
    L_UNUSED   = 3'd0,
    L_RUNNABLE = 3'd1,
    L_RUNNING  = 3'd2,
    L_SLEEPING = 3'd3,
    L_ZOMBIE   = 3'd4
  } life_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_SCAN,
    S_ORPH,
    S_RESP
  } state_t;

  // Table port controls
  typedef struct packed {
    logic we;
    logic clr;
  } pts_ctl_t;

endpackage

FILE: sv/pts_table.sv
module pts_table #(
  parameter int SLOTS = pts_pkg::SLOTS_DEF,
  parameter int EW    = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pts_pkg::pts_ctl_t        ctl,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  logic [EW-1:0]            wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output logic [EW-1:0]            rdata
);

  logic [EW-1:0]    mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [EW-1:0]    mem_q;
  logic             rv_q;

  // Track written entries; an entry never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.we) begin
      vld_r[waddr] <= 1'b1;
    end else if (ctl.clr) begin
      vld_r[waddr] <= 1'b0;
    end
  end

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
    rv_q  <= vld_r[raddr];
  end

  assign rdata = rv_q ? mem_q : '0;

endmodule

FILE: sv/process_table_scheduler_top.sv
// Channel | Ports                    | Word
// in      | in_tvalid/in_tready      | tuser: kind; tdata: wait_pid, no_hang, exit_code
// out     | out_tvalid/out_tready    | tuser: outcome; tdata: slot_index, pid_value,
//         |                          |        reaped_status
// Create, fork, dispatch and wait scan the table, one entry read per scan step; a reaping
// wait scans it once more to detach children. Yield and exit rewrite the current entry.
// Unknown kinds, and fork, yield, exit or wait without a current slot, go straight to the result.
// in_tready is high only while the sequencer is idle; one result is held in the
// output register so the next word is taken while out_tready is low.
// rst_n (synchronous) clears all entries, pid counter to 1, no current slot.
module process_table_scheduler_top #(
  parameter int SLOTS    = pts_pkg::SLOTS_DEF,
  parameter int PID_BITS = pts_pkg::PID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [16:0] wait_pid, [17] no_hang, [25:18] exit_code
  input  logic [pts_pkg::IN_DW-1:0]     in_tdata,
  // [2:0] kind
  input  logic [pts_pkg::IN_UW-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // slot_index, pid_value, reaped_status from bit 0 up
  output logic [((($clog2(SLOTS) + PID_BITS + 8) + 7) / 8) * 8 - 1:0] out_tdata,
  // [2:0] outcome
  output logic [pts_pkg::OUT_UW-1:0]    out_tuser
);

  localparam int SW     = $clog2(SLOTS);
  localparam int OUT_DW = (((SW + PID_BITS + 8) + 7) / 8) * 8;
  localparam int EW     = 3 + PID_BITS + 1 + SW + 8;
  localparam int O_PAR  = 8;
  localparam int O_PV   = 8 + SW;
  localparam int O_PID  = 9 + SW;
  localparam int O_LIFE = 9 + SW + PID_BITS;
  localparam int CW     = (PID_BITS > 16) ? PID_BITS + 1 : 17;

  pts_pkg::state_t   st_r, st_nxt;
  pts_pkg::kind_t    op_r, op_nxt;
  logic [16:0]       wpid_r, wpid_nxt;
  logic              nohang_r, nohang_nxt;
  logic [7:0]        code_r, code_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic              has_cur_r, has_cur_nxt;
  logic [PID_BITS-1:0] pidc_r, pidc_nxt;
  logic [SW-1:0]     sstart_r, sstart_nxt;
  logic [SW-1:0]     addr_r, addr_nxt;
  logic [SW:0]       cnt_r, cnt_nxt;
  logic              pv_r, pv_nxt;
  logic              plast_r, plast_nxt;
  logic [SW-1:0]     paddr_r, paddr_nxt;
  logic              child_r, child_nxt;
  logic [SW-1:0]     tgt_r, tgt_nxt;
  logic              phase_r, phase_nxt;
  logic [SW-1:0]     found_r, found_nxt;
  pts_pkg::outcome_t res_oc_r, res_oc_nxt;
  logic [SW-1:0]     res_slot_r, res_slot_nxt;
  logic [PID_BITS-1:0] res_pid_r, res_pid_nxt;
  logic [7:0]        res_st_r, res_st_nxt;
  logic              ov_r, ov_nxt;
  pts_pkg::outcome_t oc_o_r, oc_o_nxt;
  logic [SW-1:0]     slot_o_r, slot_o_nxt;
  logic [PID_BITS-1:0] pid_o_r, pid_o_nxt;
  logic [7:0]        st_o_r, st_o_nxt;

  pts_pkg::pts_ctl_t ctl;
  logic [SW-1:0]     waddr, raddr;
  logic [EW-1:0]     wdata, rd;

  // Fields of the entry just read
  pts_pkg::life_t      e_life;
  logic [PID_BITS-1:0] e_pid;
  logic                e_pv;
  logic [SW-1:0]       e_par;
  logic [7:0]          e_exit;
  logic                is_child, w_any, w_pos, pid_eq, reapable;
  logic [PID_BITS-1:0] pid_inc;

  assign e_life = pts_pkg::life_t'(rd[O_LIFE +: 3]);
  assign e_pid  = rd[O_PID +: PID_BITS];
  assign e_pv   = rd[O_PV];
  assign e_par  = rd[O_PAR +: SW];
  assign e_exit = rd[7:0];

  assign is_child = e_pv && (e_par == cur_r);
  assign w_any    = (wpid_r == 17'h1FFFF);
  assign w_pos    = !wpid_r[16] && (wpid_r != 17'd0);
  assign pid_eq   = (CW'(e_pid) == CW'(wpid_r[15:0]));
  assign reapable = is_child && (e_life == pts_pkg::L_ZOMBIE) && (w_any || (w_pos && pid_eq));
  assign pid_inc  = pidc_r + PID_BITS'(1);

  pts_table #(
    .SLOTS (SLOTS),
    .EW    (EW)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= pts_pkg::S_IDLE;
      has_cur_r <= 1'b0;
      cur_r     <= '0;
      pidc_r    <= PID_BITS'(1);
      sstart_r  <= '0;
      cnt_r     <= '0;
      pv_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      has_cur_r <= has_cur_nxt;
      cur_r     <= cur_nxt;
      pidc_r    <= pidc_nxt;
      sstart_r  <= sstart_nxt;
      cnt_r     <= cnt_nxt;
      pv_r      <= pv_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    wpid_r     <= wpid_nxt;
    nohang_r   <= nohang_nxt;
    code_r     <= code_nxt;
    addr_r     <= addr_nxt;
    plast_r    <= plast_nxt;
    paddr_r    <= paddr_nxt;
    child_r    <= child_nxt;
    tgt_r      <= tgt_nxt;
    phase_r    <= phase_nxt;
    found_r    <= found_nxt;
    res_oc_r   <= res_oc_nxt;
    res_slot_r <= res_slot_nxt;
    res_pid_r  <= res_pid_nxt;
    res_st_r   <= res_st_nxt;
    oc_o_r     <= oc_o_nxt;
    slot_o_r   <= slot_o_nxt;
    pid_o_r    <= pid_o_nxt;
    st_o_r     <= st_o_nxt;
  end

  // Next state and table access
  always_comb begin
    st_nxt       = st_r;
    op_nxt       = op_r;
    wpid_nxt     = wpid_r;
    nohang_nxt   = nohang_r;
    code_nxt     = code_r;
    cur_nxt      = cur_r;
    has_cur_nxt  = has_cur_r;
    pidc_nxt     = pidc_r;
    sstart_nxt   = sstart_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = 1'b0;
    plast_nxt    = plast_r;
    paddr_nxt    = paddr_r;
    child_nxt    = child_r;
    tgt_nxt      = tgt_r;
    phase_nxt    = phase_r;
    found_nxt    = found_r;
    res_oc_nxt   = res_oc_r;
    res_slot_nxt = res_slot_r;
    res_pid_nxt  = res_pid_r;
    res_st_nxt   = res_st_r;
    ov_nxt       = ov_r;
    oc_o_nxt     = oc_o_r;
    slot_o_nxt   = slot_o_r;
    pid_o_nxt    = pid_o_r;
    st_o_nxt     = st_o_r;
    ctl          = '0;
    waddr        = paddr_r;
    wdata        = rd;
    raddr        = addr_r;

    // Drop the held result once taken
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      pts_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = pts_pkg::kind_t'(in_tuser[2:0]);
          wpid_nxt     = in_tdata[16:0];
          nohang_nxt   = in_tdata[17];
          code_nxt     = in_tdata[25:18];
          res_oc_nxt   = pts_pkg::OC_OK;
          res_slot_nxt = '0;
          res_pid_nxt  = '0;
          res_st_nxt   = '0;
          cnt_nxt      = '0;
          addr_nxt     = '0;
          child_nxt    = 1'b0;
          tgt_nxt      = cur_r;
          phase_nxt    = 1'b0;
          st_nxt       = pts_pkg::S_RESP;
          unique case (pts_pkg::kind_t'(in_tuser[2:0]))
            pts_pkg::K_CREATE: st_nxt = pts_pkg::S_SCAN;
            pts_pkg::K_DISPATCH: begin
              if (has_cur_r) begin
                st_nxt = pts_pkg::S_RD;
              end else begin
                addr_nxt = sstart_r;
                st_nxt   = pts_pkg::S_SCAN;
              end
            end
            pts_pkg::K_FORK, pts_pkg::K_WAIT: begin
              if (has_cur_r) st_nxt = pts_pkg::S_SCAN;
              else res_oc_nxt = pts_pkg::OC_NO_CUR;
            end
            pts_pkg::K_YIELD, pts_pkg::K_EXIT: begin
              if (has_cur_r) st_nxt = pts_pkg::S_RD;
              else res_oc_nxt = pts_pkg::OC_NO_CUR;
            end
            default: st_nxt = pts_pkg::S_RESP;
          endcase
        end
      end

      pts_pkg::S_RD: begin
        raddr  = tgt_r;
        st_nxt = pts_pkg::S_MOD;
      end

      // Read-modify-write of one entry
      pts_pkg::S_MOD: begin
        waddr  = tgt_r;
        st_nxt = pts_pkg::S_RESP;
        case (op_r)
          pts_pkg::K_DISPATCH, pts_pkg::K_YIELD: begin
            if (e_life == pts_pkg::L_RUNNING) begin
              ctl.we = 1'b1;
              wdata  = {pts_pkg::L_RUNNABLE, rd[O_LIFE-1:0]};
            end
            if (op_r == pts_pkg::K_DISPATCH) begin
              cnt_nxt  = '0;
              addr_nxt = sstart_r;
              st_nxt   = pts_pkg::S_SCAN;
            end
          end
          pts_pkg::K_EXIT: begin
            if (!phase_r) begin
              ctl.we      = 1'b1;
              wdata       = {pts_pkg::L_ZOMBIE, rd[O_LIFE-1:8], code_r};
              has_cur_nxt = 1'b0;
              if (e_pv) begin
                tgt_nxt   = e_par;
                phase_nxt = 1'b1;
                st_nxt    = pts_pkg::S_RD;
              end
            end else if (e_life == pts_pkg::L_SLEEPING) begin
              ctl.we = 1'b1;
              wdata  = {pts_pkg::L_RUNNABLE, rd[O_LIFE-1:0]};
            end
          end
          pts_pkg::K_WAIT: begin
            ctl.we     = 1'b1;
            wdata      = {pts_pkg::L_SLEEPING, rd[O_LIFE-1:0]};
            res_oc_nxt = pts_pkg::OC_SLEPT;
          end
          default: st_nxt = pts_pkg::S_RESP;
        endcase
      end

      pts_pkg::S_SCAN, pts_pkg::S_ORPH: begin
        // Issue the next read
        if (cnt_r < (SW + 1)'(SLOTS)) begin
          pv_nxt    = 1'b1;
          paddr_nxt = addr_r;
          plast_nxt = (cnt_r == (SW + 1)'(SLOTS - 1));
          cnt_nxt   = cnt_r + (SW + 1)'(1);
          addr_nxt  = (addr_r == SW'(SLOTS - 1)) ? '0 : addr_r + SW'(1);
        end
        if (st_r == pts_pkg::S_ORPH) begin
          // Detach children of the reaped slot
          if (pv_r && e_pv && (e_par == found_r)) begin
            ctl.we = 1'b1;
            wdata  = {rd[EW-1:O_PV+1], 1'b0, SW'(0), e_exit};
          end
          if (pv_r && plast_r) st_nxt = pts_pkg::S_RESP;
        end else if (pv_r) begin
          case (op_r)
            pts_pkg::K_CREATE, pts_pkg::K_FORK: begin
              if (e_life == pts_pkg::L_UNUSED) begin
                ctl.we = 1'b1;
                if (op_r == pts_pkg::K_FORK) begin
                  wdata = {pts_pkg::L_RUNNABLE, pidc_r, 1'b1, cur_r, 8'd0};
                end else begin
                  wdata       = {pts_pkg::L_RUNNABLE, pidc_r, 1'b0, SW'(0), 8'd0};
                  cur_nxt     = paddr_r;
                  has_cur_nxt = 1'b1;
                end
                pidc_nxt     = (pid_inc == '0) ? PID_BITS'(1) : pid_inc;
                res_slot_nxt = paddr_r;
                res_pid_nxt  = pidc_r;
                pv_nxt       = 1'b0;
                st_nxt       = pts_pkg::S_RESP;
              end else if (plast_r) begin
                res_oc_nxt = pts_pkg::OC_FULL;
                st_nxt     = pts_pkg::S_RESP;
              end
            end
            pts_pkg::K_DISPATCH: begin
              if (e_life == pts_pkg::L_RUNNABLE) begin
                ctl.we       = 1'b1;
                wdata        = {pts_pkg::L_RUNNING, rd[O_LIFE-1:0]};
                cur_nxt      = paddr_r;
                has_cur_nxt  = 1'b1;
                sstart_nxt   = (paddr_r == SW'(SLOTS - 1)) ? '0 : paddr_r + SW'(1);
                res_slot_nxt = paddr_r;
                res_pid_nxt  = e_pid;
                pv_nxt       = 1'b0;
                st_nxt       = pts_pkg::S_RESP;
              end else if (plast_r) begin
                res_oc_nxt = pts_pkg::OC_NONE_RUN;
                st_nxt     = pts_pkg::S_RESP;
              end
            end
            pts_pkg::K_WAIT: begin
              child_nxt = child_r | is_child;
              if (reapable) begin
                ctl.clr      = 1'b1;
                found_nxt    = paddr_r;
                res_slot_nxt = paddr_r;
                res_pid_nxt  = e_pid;
                res_st_nxt   = e_exit;
                cnt_nxt      = '0;
                addr_nxt     = '0;
                pv_nxt       = 1'b0;
                st_nxt       = pts_pkg::S_ORPH;
              end else if (plast_r) begin
                if (nohang_r) begin
                  res_oc_nxt = pts_pkg::OC_NONE_READY;
                  st_nxt     = pts_pkg::S_RESP;
                end else if (!(child_r || is_child)) begin
                  res_oc_nxt = pts_pkg::OC_NO_CHILD;
                  st_nxt     = pts_pkg::S_RESP;
                end else begin
                  tgt_nxt = cur_r;
                  st_nxt  = pts_pkg::S_RD;
                end
              end
            end
            default: st_nxt = pts_pkg::S_RESP;
          endcase
        end
      end

      // Hand the result to the output register
      pts_pkg::S_RESP: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          oc_o_nxt   = res_oc_r;
          slot_o_nxt = res_slot_r;
          pid_o_nxt  = res_pid_r;
          st_o_nxt   = res_st_r;
          st_nxt     = pts_pkg::S_IDLE;
        end
      end

      default: st_nxt = pts_pkg::S_IDLE;
    endcase
  end

  assign in_tready  = (st_r == pts_pkg::S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = {(pts_pkg::OUT_UW - 3)'(0), oc_o_r};
  assign out_tdata  = {(OUT_DW - SW - PID_BITS - 8)'(0), st_o_r, pid_o_r, slot_o_r};

  // The current slot is lost only through an exit
  a_cur_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(has_cur_r) |-> $past(op_r == pts_pkg::K_EXIT))
    else $error("current slot dropped outside exit");

  // Pid zero is never handed out
  a_pid_nz: assert property (@(posedge clk) disable iff (!rst_n)
    pidc_r != '0)
    else $error("pid counter reached zero");

  // Scan counter stays within the table
  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (SW + 1)'(SLOTS))
    else $error("scan counter past table end");

  // A new result appears only from the response state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r == pts_pkg::S_RESP))
    else $error("result raised outside response state");

endmodule

FILE: verif/tb_process_table_scheduler_top.sv
`timescale 1ns / 1ps

module tb_process_table_scheduler_top;

  localparam int NSLOT    = 64;
  localparam int NO_PROC  = NSLOT;
  localparam int IDLE_LIM = 4000;
  localparam int RAND_OPS = 1800;
  localparam logic [2:0] K_BAD6 = 3'd6;
  localparam logic [2:0] K_BAD7 = 3'd7;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [5:0]  slot;
    logic [15:0] pid;
    logic [7:0]  status;
  } reply_t;

  typedef struct {
    logic [2:0]        kind;
    logic signed [16:0] wpid;
    logic              nohang;
    logic [7:0]        code;
    bit                typed;
    reply_t            want;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [7:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [7:0]  out_tuser;

  // shadow process table
  pts_pkg::life_t tbl_life[NSLOT];
  logic [15:0] tbl_pid[NSLOT];
  int          tbl_par[NSLOT];
  logic [7:0]  tbl_code[NSLOT];
  logic [15:0] pid_next;
  int          cur_slot;
  int          scan_from;

  reply_t  pending_replies[$];
  op_row_t dir_ops[$];
  int      errors = 0;
  int      quiet_cycles = 0;

  process_table_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] take_pid();
    logic [15:0] p;
    p = pid_next;
    pid_next = pid_next + 16'd1;
    if (pid_next == 16'd0) pid_next = 16'd1;
    return p;
  endfunction

  // apply one operation to the shadow table and return its reply
  function automatic reply_t table_op(logic [2:0] k, logic signed [16:0] wp, logic nh,
                                      logic [7:0] code);
    reply_t r;
    int cur, s, found, par;
    bit has_cur, child;
    r = '0;
    cur = cur_slot;
    has_cur = cur < NSLOT;
    case (k)
      pts_pkg::K_CREATE, pts_pkg::K_FORK: begin
        if (k == pts_pkg::K_FORK && !has_cur) begin
          r.outcome = pts_pkg::OC_NO_CUR;
        end else begin
          s = NO_PROC;
          for (int i = NSLOT - 1; i >= 0; i--) if (tbl_life[i] == pts_pkg::L_UNUSED) s = i;
          if (s == NO_PROC) begin
            r.outcome = pts_pkg::OC_FULL;
          end else begin
            tbl_pid[s] = take_pid();
            tbl_life[s] = pts_pkg::L_RUNNABLE;
            tbl_code[s] = 8'd0;
            if (k == pts_pkg::K_FORK) begin
              tbl_par[s] = cur;
            end else begin
              tbl_par[s] = NO_PROC;
              cur_slot = s;
            end
            r.slot = s[5:0];
            r.pid = tbl_pid[s];
          end
        end
      end
      pts_pkg::K_DISPATCH: begin
        if (has_cur && tbl_life[cur] == pts_pkg::L_RUNNING) tbl_life[cur] = pts_pkg::L_RUNNABLE;
        r.outcome = pts_pkg::OC_NONE_RUN;
        for (int i = 0; i < NSLOT; i++) begin
          s = (scan_from + i) % NSLOT;
          if (r.outcome == pts_pkg::OC_NONE_RUN && tbl_life[s] == pts_pkg::L_RUNNABLE) begin
            tbl_life[s] = pts_pkg::L_RUNNING;
            cur_slot = s;
            scan_from = (s + 1) % NSLOT;
            r.outcome = pts_pkg::OC_OK;
            r.slot = s[5:0];
            r.pid = tbl_pid[s];
          end
        end
      end
      pts_pkg::K_YIELD: begin
        if (!has_cur) r.outcome = pts_pkg::OC_NO_CUR;
        else if (tbl_life[cur] == pts_pkg::L_RUNNING) tbl_life[cur] = pts_pkg::L_RUNNABLE;
      end
      pts_pkg::K_EXIT: begin
        if (!has_cur) begin
          r.outcome = pts_pkg::OC_NO_CUR;
        end else begin
          par = tbl_par[cur];
          tbl_life[cur] = pts_pkg::L_ZOMBIE;
          tbl_code[cur] = code;
          if (par < NSLOT && tbl_life[par] == pts_pkg::L_SLEEPING)
            tbl_life[par] = pts_pkg::L_RUNNABLE;
          cur_slot = NO_PROC;
        end
      end
      pts_pkg::K_WAIT: begin
        if (!has_cur) begin
          r.outcome = pts_pkg::OC_NO_CUR;
        end else begin
          child = 0;
          found = NO_PROC;
          for (int i = 0; i < NSLOT; i++) begin
            if (found == NO_PROC && tbl_par[i] == cur) begin
              child = 1;
              if (tbl_life[i] == pts_pkg::L_ZOMBIE &&
                  (wp == -17'sd1 || (wp > 0 && tbl_pid[i] == wp[15:0])))
                found = i;
            end
          end
          if (found < NSLOT) begin
            r.slot = found[5:0];
            r.pid = tbl_pid[found];
            r.status = tbl_code[found];
            tbl_life[found] = pts_pkg::L_UNUSED;
            tbl_pid[found] = '0;
            tbl_par[found] = NO_PROC;
            tbl_code[found] = '0;
            for (int i = 0; i < NSLOT; i++) if (tbl_par[i] == found) tbl_par[i] = NO_PROC;
          end else if (nh) begin
            r.outcome = pts_pkg::OC_NONE_READY;
          end else if (!child) begin
            r.outcome = pts_pkg::OC_NO_CHILD;
          end else begin
            tbl_life[cur] = pts_pkg::L_SLEEPING;
            r.outcome = pts_pkg::OC_SLEPT;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one word; hold valid across a burst, predict on acceptance
  task automatic send_word(logic [2:0] k, logic signed [16:0] wp, logic nh, logic [7:0] code,
                           bit typed, reply_t want);
    reply_t r;
    in_tvalid <= 1'b1;
    in_tuser <= {5'd0, k};
    in_tdata <= {6'd0, code, nh, wp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = table_op(k, wp, nh, code);
    pending_replies.push_back(typed ? want : r);
  endtask

  int burst_left = 0;

  // insert a random gap between bursts
  task automatic pace();
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  function automatic logic signed [16:0] pick_wpid();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return -17'sd1;
    if (sel < 8) return {1'b0, tbl_pid[$urandom_range(0, NSLOT - 1)]};
    if (sel < 9) return 17'sd0;
    return {1'b0, 16'($urandom_range(0, 65535))};
  endfunction

  // stimulus
  initial begin
    int w;
    logic [2:0] k;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_life[i] = pts_pkg::L_UNUSED;
      tbl_pid[i] = '0;
      tbl_par[i] = NO_PROC;
      tbl_code[i] = '0;
    end
    pid_next = 16'd1;
    cur_slot = NO_PROC;
    scan_from = 0;

    dir_ops.push_back('{pts_pkg::K_YIELD, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_NO_CUR, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_FORK, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_NO_CUR, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_EXIT, -17'sd1, 1'b0, 8'd7, 1,
                        '{pts_pkg::OC_NO_CUR, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_WAIT, -17'sd1, 1'b1, 8'd0, 1,
                        '{pts_pkg::OC_NO_CUR, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_NONE_RUN, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{K_BAD6, -17'sd1, 1'b1, 8'hFF, 1, '{3'd0, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{K_BAD7, 17'sd65535, 1'b1, 8'hFF, 1, '{3'd0, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_CREATE, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_OK, 6'd0, 16'd1, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_FORK, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_OK, 6'd1, 16'd2, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_WAIT, -17'sd1, 1'b1, 8'd0, 1,
                        '{pts_pkg::OC_NONE_READY, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_OK, 6'd0, 16'd1, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_YIELD, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_OK, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 0, '0});
    dir_ops.push_back('{pts_pkg::K_WAIT, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_NO_CHILD, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_EXIT, -17'sd1, 1'b0, 8'hFF, 1,
                        '{pts_pkg::OC_OK, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 0, '0});
    dir_ops.push_back('{pts_pkg::K_WAIT, 17'sd2, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_OK, 6'd1, 16'd2, 8'hFF}});
    dir_ops.push_back('{pts_pkg::K_WAIT, 17'sd65535, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_NO_CHILD, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_FORK, -17'sd1, 1'b0, 8'd0, 0, '0});
    dir_ops.push_back('{pts_pkg::K_WAIT, 17'sd0, 1'b1, 8'd0, 0, '0});
    dir_ops.push_back('{pts_pkg::K_WAIT, -17'sd1, 1'b0, 8'd0, 1,
                        '{pts_pkg::OC_SLEPT, 6'd0, 16'd0, 8'd0}});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 0, '0});
    dir_ops.push_back('{pts_pkg::K_EXIT, -17'sd1, 1'b0, 8'hA5, 0, '0});
    dir_ops.push_back('{pts_pkg::K_DISPATCH, -17'sd1, 1'b0, 8'd0, 0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_ops[i]) begin
      pace();
      send_word(dir_ops[i].kind, dir_ops[i].wpid, dir_ops[i].nohang, dir_ops[i].code,
                dir_ops[i].typed, dir_ops[i].want);
    end

    // random process lifecycles
    for (int n = 0; n < RAND_OPS; n++) begin
      pace();
      w = $urandom_range(0, 99);
      if (cur_slot == NO_PROC && w < 50) k = (w < 10) ? pts_pkg::K_CREATE : pts_pkg::K_DISPATCH;
      else if (w < 4)  k = pts_pkg::K_CREATE;
      else if (w < 30) k = pts_pkg::K_FORK;
      else if (w < 50) k = pts_pkg::K_DISPATCH;
      else if (w < 58) k = pts_pkg::K_YIELD;
      else if (w < 72) k = pts_pkg::K_EXIT;
      else             k = pts_pkg::K_WAIT;
      send_word(k, pick_wpid(), 1'($urandom_range(0, 1)), 8'($urandom), 0, '0);
    end

    // fill the table until it reports full
    for (int n = 0; n < NSLOT + 3; n++) begin
      pace();
      send_word(pts_pkg::K_CREATE, -17'sd1, 1'b0, 8'd0, 0, '0);
    end
    send_word(pts_pkg::K_FORK, -17'sd1, 1'b0, 8'd0, 0, '0);
    in_tvalid <= 1'b0;

    // drain
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("process_table_scheduler_top test passed");
    end else begin
      $display("process_table_scheduler_top test failed");
    end
    $finish;
  end

  // receiver stall pattern: stall-free stretches and random back-pressure
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    reply_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[2:0], out_tdata[5:0], out_tdata[21:6], out_tdata[29:22]};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result word outcome=%0d slot=%0d pid=%0d status=%0d",
                 $time, got.outcome, got.slot, got.pid, got.status);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.outcome !== want.outcome)
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
        if (got.slot !== want.slot)
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, got.slot);
        if (got.pid !== want.pid)
          $display("%0t: pid_value expected %0d actual %0d", $time, want.pid, got.pid);
        if (got.status !== want.status)
          $display("%0t: reaped_status expected %0d actual %0d", $time, want.status,
                   got.status);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIM) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_replies.size());
      $display("process_table_scheduler_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: files.f
sv/pts_pkg.sv
sv/pts_table.sv
sv/process_table_scheduler_top.sv
verif/tb_process_table_scheduler_top.sv
